>>> rtl/roi_finder_pad_merge_defines.svh
// Assertion macros shared by the region finder RTL.
// Each takes a label, an antecedent and a consequent, clocked on clock and
// disabled while reset is high.
`ifndef ROI_FINDER_PAD_MERGE_DEFINES_SVH
`define ROI_FINDER_PAD_MERGE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RFPM_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rfpm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RFPM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rfpm assertion failed");

`endif

>>> rtl/rfpm_pkg.sv
// ----------------------------------------------------------------------------
// rfpm_pkg
// Types and constants for the region-of-interest finder with pad and merge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfpm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int IDX_W      = 13;
   localparam int HI_W       = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_SAMPLES = 8192;
   localparam logic [IDX_W-1:0] IDX_LIMIT =
      IDX_W'(((MAX_SAMPLES > 8192) ? 8192 : MAX_SAMPLES) - 1);

   // Event queue between front and back
   localparam int EVQ_DEPTH = 4;
   localparam int EVQ_PTR_W = 2;
   localparam int EVQ_CNT_W = 3;

   // Result queue at the output
   localparam int RSQ_DEPTH = 4;
   localparam int RSQ_PTR_W = 2;
   localparam int RSQ_CNT_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OPEN_THR  = 2'd0,
      CSR_CLOSE_THR = 2'd1,
      CSR_PAD_LOW   = 2'd2,
      CSR_PAD_HIGH  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_sample;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] roi_start;
      logic [IDX_W-1:0] roi_end;
      logic             run_last;
   } rsp_type;

   // One classified sample: a closed padded region and/or end of channel
   typedef struct packed {
      logic             closed;
      logic             last;
      logic [IDX_W-1:0] lo;
      logic [HI_W-1:0]  hi;
      logic [IDX_W-1:0] idx;
   } evt_type;

endpackage

>>> rtl/rfpm_front.sv
// ----------------------------------------------------------------------------
// rfpm_front
// Tracks sample index and hysteresis region state, pads closed regions and
// queues close / end-of-channel events for the merge stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "roi_finder_pad_merge_defines.svh"

module rfpm_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  rfpm_pkg::req_type                   req_data,
   input  logic                                csr_wr_en,
   input  logic [rfpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rfpm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                evt_valid,
   output rfpm_pkg::evt_type                   evt_head,
   input  logic                                evt_pop
);

   logic signed [rfpm_pkg::SAMPLE_W-1:0] open_thr_ff, close_thr_ff;
   logic [rfpm_pkg::IDX_W-1:0]           pad_low_ff, pad_high_ff;

   logic [rfpm_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                       in_region_ff, in_region_in;
   logic [rfpm_pkg::IDX_W-1:0] raw_start_ff, raw_start_in;

   rfpm_pkg::evt_type          evq_ff [rfpm_pkg::EVQ_DEPTH];
   logic [rfpm_pkg::EVQ_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [rfpm_pkg::EVQ_CNT_W-1:0] count_ff, count_in;

   logic              accept, closing, opening, evq_wr;
   rfpm_pkg::evt_type evt_new;

   always_comb begin
      accept  = push && !full;
      closing = in_region_ff &&
                ((req_data.sample < close_thr_ff) || req_data.last_sample);
      opening = !in_region_ff && (req_data.sample > open_thr_ff);

      evt_new.closed = closing;
      evt_new.last   = req_data.last_sample;
      evt_new.lo     = (raw_start_ff > pad_low_ff) ? (raw_start_ff - pad_low_ff) : '0;
      evt_new.hi     = {1'b0, idx_ff} + {1'b0, pad_high_ff};
      evt_new.idx    = idx_ff;

      evq_wr = accept && (closing || req_data.last_sample);

      idx_in       = idx_ff;
      in_region_in = in_region_ff;
      raw_start_in = raw_start_ff;
      if (accept) begin
         if (req_data.last_sample) begin
            idx_in       = '0;
            in_region_in = 1'b0;
            raw_start_in = '0;
         end else begin
            if (idx_ff < rfpm_pkg::IDX_LIMIT) begin
               idx_in = idx_ff + 1'b1;
            end
            if (closing) begin
               in_region_in = 1'b0;
               raw_start_in = '0;
            end else if (opening) begin
               in_region_in = 1'b1;
               raw_start_in = idx_ff;
            end
         end
      end

      count_in = count_ff + rfpm_pkg::EVQ_CNT_W'(evq_wr) - rfpm_pkg::EVQ_CNT_W'(evt_pop);
   end

   assign full      = (count_ff == rfpm_pkg::EVQ_CNT_W'(rfpm_pkg::EVQ_DEPTH));
   assign evt_valid = (count_ff != '0);
   assign evt_head  = evq_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         open_thr_ff  <= '0;
         close_thr_ff <= '0;
         pad_low_ff   <= '0;
         pad_high_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rfpm_pkg::CSR_OPEN_THR:  open_thr_ff  <= csr_wdata;
            rfpm_pkg::CSR_CLOSE_THR: close_thr_ff <= csr_wdata;
            rfpm_pkg::CSR_PAD_LOW:   pad_low_ff   <= csr_wdata[rfpm_pkg::IDX_W-1:0];
            rfpm_pkg::CSR_PAD_HIGH:  pad_high_ff  <= csr_wdata[rfpm_pkg::IDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         in_region_ff <= 1'b0;
         raw_start_ff <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         idx_ff       <= idx_in;
         in_region_ff <= in_region_in;
         raw_start_ff <= raw_start_in;
         count_ff     <= count_in;
         if (evq_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (evt_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (evq_wr) begin
         evq_ff[wr_ptr_ff] <= evt_new;
      end
   end

   `RFPM_ASSERT_SAME(a_evq_bound, 1'b1, count_ff <= rfpm_pkg::EVQ_CNT_W'(rfpm_pkg::EVQ_DEPTH))
   `RFPM_ASSERT_NEXT(a_last_clears, accept && req_data.last_sample, (idx_ff == '0) && !in_region_ff)
   `RFPM_ASSERT_SAME(a_no_pop_empty, evt_pop, count_ff != '0)

endmodule

>>> rtl/rfpm_back.sv
// ----------------------------------------------------------------------------
// rfpm_back
// Merges padded regions into the pending region, emits finished regions and
// buffers them in the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "roi_finder_pad_merge_defines.svh"

module rfpm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                evt_valid,
   input  rfpm_pkg::evt_type   evt_head,
   output logic                evt_pop,
   output logic                empty,
   input  logic                pop,
   output rfpm_pkg::rsp_type   rsp_data
);

   logic                       pend_valid_ff, pend_valid_in;
   logic [rfpm_pkg::IDX_W-1:0] pend_low_ff, pend_low_in;
   logic [rfpm_pkg::HI_W-1:0]  pend_high_ff, pend_high_in;

   logic              second_valid_ff, second_valid_in;
   rfpm_pkg::rsp_type second_ff;

   rfpm_pkg::rsp_type              rsq_ff [rfpm_pkg::RSQ_DEPTH];
   logic [rfpm_pkg::RSQ_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [rfpm_pkg::RSQ_CNT_W-1:0] count_ff;

   logic [rfpm_pkg::HI_W:0]    ph_inc;
   logic                       merge, emit_a, emit_b, room, rsq_wr, rsq_rd;
   logic                       pv2;
   logic [rfpm_pkg::IDX_W-1:0] pl2;
   logic [rfpm_pkg::HI_W-1:0]  ph2, end_b;
   rfpm_pkg::rsp_type          res_a, res_b, wr_data;

   always_comb begin
      ph_inc = {1'b0, pend_high_ff} + 1'b1;
      merge  = evt_head.closed && pend_valid_ff &&
               ({2'b00, evt_head.lo} <= ph_inc);
      emit_a = evt_head.closed && pend_valid_ff && !merge;

      pv2 = pend_valid_ff || evt_head.closed;
      pl2 = (evt_head.closed && !merge) ? evt_head.lo : pend_low_ff;
      if (!evt_head.closed) begin
         ph2 = pend_high_ff;
      end else if (merge) begin
         ph2 = (evt_head.hi > pend_high_ff) ? evt_head.hi : pend_high_ff;
      end else begin
         ph2 = evt_head.hi;
      end

      // clamp the final region to the channel's last index
      emit_b = evt_head.last && pv2;
      end_b  = (ph2 > {1'b0, evt_head.idx}) ? {1'b0, evt_head.idx} : ph2;

      res_a.roi_start = pend_low_ff;
      res_a.roi_end   = pend_high_ff[rfpm_pkg::IDX_W-1:0];
      res_a.run_last  = !emit_b;
      res_b.roi_start = pl2;
      res_b.roi_end   = end_b[rfpm_pkg::IDX_W-1:0];
      res_b.run_last  = 1'b1;

      room    = (count_ff != rfpm_pkg::RSQ_CNT_W'(rfpm_pkg::RSQ_DEPTH));
      evt_pop = evt_valid && !second_valid_ff && room;

      // hold the final region in second_ff, until the result queue has room, when a request yields two results
      if (second_valid_ff) begin
         rsq_wr  = room;
         wr_data = second_ff;
      end else begin
         rsq_wr  = evt_pop && (emit_a || emit_b);
         wr_data = emit_a ? res_a : res_b;
      end
      second_valid_in = second_valid_ff ? !room : (evt_pop && emit_a && emit_b);

      pend_valid_in = pend_valid_ff;
      pend_low_in   = pend_low_ff;
      pend_high_in  = pend_high_ff;
      if (evt_pop) begin
         if (evt_head.last) begin
            pend_valid_in = 1'b0;
            pend_low_in   = '0;
            pend_high_in  = '0;
         end else begin
            pend_valid_in = pv2;
            pend_low_in   = pl2;
            pend_high_in  = ph2;
         end
      end

      rsq_rd = pop && !empty;
   end

   assign empty    = (count_ff == '0);
   assign rsp_data = rsq_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff   <= 1'b0;
         pend_low_ff     <= '0;
         pend_high_ff    <= '0;
         second_valid_ff <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         pend_valid_ff   <= pend_valid_in;
         pend_low_ff     <= pend_low_in;
         pend_high_ff    <= pend_high_in;
         second_valid_ff <= second_valid_in;
         count_ff        <= count_ff + rfpm_pkg::RSQ_CNT_W'(rsq_wr)
                                     - rfpm_pkg::RSQ_CNT_W'(rsq_rd);
         if (rsq_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsq_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!second_valid_ff) begin
         second_ff <= res_b;
      end
      if (rsq_wr) begin
         rsq_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `RFPM_ASSERT_SAME(a_rsq_bound, 1'b1, count_ff <= rfpm_pkg::RSQ_CNT_W'(rfpm_pkg::RSQ_DEPTH))
   `RFPM_ASSERT_SAME(a_hold_while_second, second_valid_ff, !evt_pop)
   `RFPM_ASSERT_NEXT(a_last_clears_pend, evt_pop && evt_head.last, !pend_valid_ff)

endmodule

>>> rtl/roi_finder_pad_merge.sv
// With both queues empty, a request's first result passes the event queue, then the result queue,
// before it is on the result ports; a second result of the same request waits in second_ff.
// The finder takes one request per cycle while not full; the merge stage handles one request per
// cycle when the result queue has room and pauses on a request that ends a channel with two results.
// A 4-entry event queue and a 4-entry result queue decouple the two sides.
// Reset (synchronous, active high) clears the registers, the region state and both queues.
// ----------------------------------------------------------------------------
// roi_finder_pad_merge
// Top level of the region-of-interest finder: front classifier and back merger.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module roi_finder_pad_merge (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  rfpm_pkg::req_type               req_data,
   output logic                            empty,
   input  logic                            pop,
   output rfpm_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [rfpm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rfpm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic              evt_valid, evt_pop;
   rfpm_pkg::evt_type evt_head;

   rfpm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .evt_valid (evt_valid),
      .evt_head  (evt_head),
      .evt_pop   (evt_pop)
   );

   rfpm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .evt_valid (evt_valid),
      .evt_head  (evt_head),
      .evt_pop   (evt_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/tb_roi_finder_pad_merge.sv
// ----------------------------------------------------------------------------
// tb_roi_finder_pad_merge
// Self-checking bench for the hysteresis region finder with pad and merge.
// Streams channels of samples through the request queue and predicts the
// padded, merged regions that each sample releases. Every popped region is
// checked field by field against the oldest prediction. Phases vary the
// thresholds, the pads and the idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_roi_finder_pad_merge;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASES         = 12;
   localparam int PHASE_REQUESTS = 80;
   localparam int LONG_HOLD      = 300;
   localparam int DIRECTED_LEN   = 27;

   class roi_scoreboard;
      int open_thr, close_thr, pad_low, pad_high;
      int cur_index, raw_start, pend_low, pend_high;
      bit in_region, pend_valid;
      rfpm_pkg::rsp_type expected_rois[$];
      rfpm_pkg::rsp_type fresh[$];
      int errors, n_requests, n_channels, n_rois, n_merges;

      function void write_reg(rfpm_pkg::csr_index_type which,
                              logic [rfpm_pkg::CSR_DATA_W-1:0] value);
         case (which)
            rfpm_pkg::CSR_OPEN_THR:  open_thr = $signed(value);
            rfpm_pkg::CSR_CLOSE_THR: close_thr = $signed(value);
            rfpm_pkg::CSR_PAD_LOW:   pad_low = value[rfpm_pkg::IDX_W-1:0];
            rfpm_pkg::CSR_PAD_HIGH:  pad_high = value[rfpm_pkg::IDX_W-1:0];
            default: ;
         endcase
      endfunction

      function void add_roi(int lo, int hi);
         rfpm_pkg::rsp_type r;
         r.roi_start = lo[rfpm_pkg::IDX_W-1:0];
         r.roi_end   = hi[rfpm_pkg::IDX_W-1:0];
         r.run_last  = 1'b0;
         fresh.insert(fresh.size(), r);
      endfunction

      function void note_request(rfpm_pkg::req_type req);
         int s, idx, lo, hi, rs;
         bit closed;
         s = $signed(req.sample);
         idx = cur_index;
         closed = 1'b0;
         rs = 0;
         fresh.delete();
         n_requests++;
         if (in_region) begin
            if (s < close_thr || req.last_sample) begin
               closed = 1'b1;
               rs = raw_start;
               in_region = 1'b0;
               raw_start = 0;
            end
         end else if (s > open_thr) begin
            raw_start = idx;
            in_region = 1'b1;
         end
         if (closed) begin
            lo = (rs > pad_low) ? rs - pad_low : 0;
            hi = idx + pad_high;
            if (pend_valid && lo <= pend_high + 1) begin
               if (hi > pend_high) pend_high = hi;
               n_merges++;
            end else begin
               if (pend_valid) add_roi(pend_low, pend_high);
               pend_valid = 1'b1;
               pend_low = lo;
               pend_high = hi;
            end
         end
         if (req.last_sample) begin
            // clamp the pending end to the channel's last index, then clear
            if (pend_valid) add_roi(pend_low, (pend_high > idx) ? idx : pend_high);
            cur_index = 0;
            in_region = 1'b0;
            raw_start = 0;
            pend_valid = 1'b0;
            pend_low = 0;
            pend_high = 0;
            n_channels++;
         end else if (idx < int'(rfpm_pkg::IDX_LIMIT)) begin
            cur_index = idx + 1;
         end
         if (fresh.size() > 0) fresh[fresh.size() - 1].run_last = 1'b1;
         foreach (fresh[i]) expected_rois.insert(expected_rois.size(), fresh[i]);
      endfunction

      function void check_result(rfpm_pkg::rsp_type got);
         rfpm_pkg::rsp_type want;
         if (expected_rois.size() == 0) begin
            $error("unexpected region: roi_start %0d roi_end %0d run_last %0d",
                   got.roi_start, got.roi_end, got.run_last);
            errors++;
            return;
         end
         want = expected_rois.pop_front();
         n_rois++;
         if (got.roi_start !== want.roi_start) begin
            $error("roi_start: expected %0d, got %0d", want.roi_start, got.roi_start);
            errors++;
         end
         if (got.roi_end !== want.roi_end) begin
            $error("roi_end: expected %0d, got %0d", want.roi_end, got.roi_end);
            errors++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
            errors++;
         end
      endfunction

      function void check_drained();
         if (expected_rois.size() != 0) begin
            $error("%0d regions never arrived", expected_rois.size());
            errors++;
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            push = 1'b0;
   logic                            full;
   rfpm_pkg::req_type               req_data = '0;
   logic                            empty;
   logic                            pop = 1'b0;
   rfpm_pkg::rsp_type               rsp_data;
   logic                            csr_wr_en = 1'b0;
   logic [rfpm_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [rfpm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_serial = 0;
   int hold_done = 0;
   int hold_left = 0;
   int n_settings = 0;
   roi_scoreboard sb = new();

   roi_finder_pad_merge dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && push && !full) sb.note_request(req_data);
   end

   // receiver: random stalls, plus a long hold-off when the main flow asks for one
   always @(posedge clock) begin
      if (!reset && pop && !empty) sb.check_result(rsp_data);
      if (hold_serial != hold_done) begin
         hold_done <= hold_serial;
         hold_left <= LONG_HOLD;
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
   end

   function automatic logic [15:0] clamp16(input int v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   // burst samples open and hold a region, quiet ones close it or stay out
   function automatic logic [15:0] pick_sample(input bit burst);
      int lo_v, hi_v, r;
      r = $urandom_range(99);
      if (r < 10) return 16'($urandom);
      if (r < 16) begin
         case ($urandom_range(3))
            0: return clamp16(sb.open_thr);
            1: return clamp16(sb.open_thr + 1);
            2: return clamp16(sb.close_thr);
            default: return clamp16(sb.close_thr - 1);
         endcase
      end
      if (burst) begin
         lo_v = (sb.open_thr + 1 > sb.close_thr) ? sb.open_thr + 1 : sb.close_thr;
         if (lo_v > 32767) lo_v = sb.close_thr;
         hi_v = 32767;
      end else begin
         lo_v = -32768;
         hi_v = (sb.close_thr - 1 < sb.open_thr) ? sb.close_thr - 1 : sb.open_thr;
         if (hi_v < -32768) hi_v = sb.open_thr;
      end
      return clamp16(lo_v + int'($urandom_range(hi_v - lo_v)));
   endfunction

   task automatic send_request(input rfpm_pkg::req_type r);
      if (send_idle_pct > 0) begin
         while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clock);
         end
      end
      push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic send_channel(input int len);
      rfpm_pkg::req_type r;
      bit burst;
      int run;
      burst = 1'b0;
      run = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
         if (run == 0) begin
            burst = !burst;
            if (burst) run = $urandom_range(6, 1);
            else if ($urandom_range(3) == 0) run = $urandom_range(40, 1);
            else run = $urandom_range(8, 1);
         end
         run--;
         r.sample = pick_sample(burst);
         r.last_sample = (i == len - 1);
         send_request(r);
      end
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      @(posedge clock);
      while (sb.expected_rois.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input rfpm_pkg::csr_index_type which,
                            input logic [rfpm_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(which, value);
   endtask

   task automatic apply_setting(input int o, input int c, input int pl, input int ph);
      write_csr(rfpm_pkg::CSR_OPEN_THR, clamp16(o));
      write_csr(rfpm_pkg::CSR_CLOSE_THR, clamp16(c));
      write_csr(rfpm_pkg::CSR_PAD_LOW, rfpm_pkg::CSR_DATA_W'(pl));
      write_csr(rfpm_pkg::CSR_PAD_HIGH, rfpm_pkg::CSR_DATA_W'(ph));
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   task automatic choose_setting(input int p);
      int o, c, pl, ph;
      case (p)
         1:  begin o = 32767;  c = -32768; pl = 0;    ph = 0;    end
         4:  begin o = -32768; c = 32767;  pl = 8191; ph = 8191; end
         7:  begin o = -32768; c = -32768; pl = 8191; ph = 0;    end
         10: begin o = 0;      c = 500;    pl = 0;    ph = 8191; end
         default: begin
            o = int'($urandom_range(4000)) - 2000;
            c = o - int'($urandom_range(1500));
            pl = ($urandom_range(3) == 0) ? $urandom_range(60) : $urandom_range(12);
            ph = ($urandom_range(3) == 0) ? $urandom_range(60) : $urandom_range(12);
         end
      endcase
      apply_setting(o, c, pl, ph);
   endtask

   initial begin
      int dir_sample[DIRECTED_LEN] = '{32767,
         0, 101, 50, 49, 0, 0, 100, 300, -32768, 0, 150, 40, 0,
         5, -32768,
         200, 0, 0, 0, 0, 0, 0, 0, 0, 200, 200};
      rfpm_pkg::req_type r;
      int sent, len, pick;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // opening on the last sample, boundary samples, merge, channel with no
      // region, and a last sample that releases two regions
      apply_setting(100, 50, 2, 3);
      for (int i = 0; i < DIRECTED_LEN; i++) begin
         r.sample = clamp16(dir_sample[i]);
         r.last_sample = (i == 0 || i == 13 || i == 15 || i == DIRECTED_LEN - 1);
         send_request(r);
      end
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 72; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 72; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
         endcase
         choose_setting(p);
         // hold the receiver off so both queues fill and the input stalls
         if (p == 2) hold_serial++;
         sent = 0;
         while (sent < PHASE_REQUESTS) begin
            pick = $urandom_range(99);
            if (pick < 5) len = 1;
            else if (pick < 80) len = $urandom_range(40, 2);
            else len = $urandom_range(200, 41);
            send_channel(len);
            sent += len;
         end
         wait_drained();
      end

      sb.check_drained();
      $display("covered %0d requests in %0d channels under %0d register settings",
               sb.n_requests, sb.n_channels, n_settings);
      $display("checked %0d regions, %0d merges predicted, %0d mismatches",
               sb.n_rois, sb.n_merges, sb.errors);
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rfpm_pkg.sv
rtl/rfpm_front.sv
rtl/rfpm_back.sv
rtl/roi_finder_pad_merge.sv
tb/tb_roi_finder_pad_merge.sv
